>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL; compile them out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising edge, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Types, codes and helpers shared by the shell line tokenizer modules.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_WEND = 2'd1,
        KIND_OP   = 2'd2,
        KIND_EOL  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        OP_APPEND   = 3'd0,
        OP_REDIR_ER = 3'd1,
        OP_REDIR_OU = 3'd2,
        OP_REDIR_IN = 3'd3,
        OP_PIPE     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        LEAD_NONE = 2'd0,
        LEAD_GT   = 2'd1,
        LEAD_TWO  = 2'd2
    } lead_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        op_t        op;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [CNT_W-1:0]          count;
    } lex_list_t;

    // Append one result unless the list is full.
    function automatic lex_list_t put_res(lex_list_t l, kind_t k, logic [7:0] ch, op_t op);
        lex_list_t r;
        r = l;
        if (r.count < CNT_W'(MAX_RESULTS))
        begin
            r.res[r.count[IDX_W-1:0]].kind = k;
            r.res[r.count[IDX_W-1:0]].ch   = ch;
            r.res[r.count[IDX_W-1:0]].op   = op;
            r.count = r.count + CNT_W'(1);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/slt_lexer.sv
// ----------------------------------------------------------------------------
// slt_lexer
// Lexer state and the single-pass decode of one byte into its result list.
// ----------------------------------------------------------------------------
module slt_lexer
    import slt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] char_in,
    input  logic       line_end,
    output lex_list_t  results
);

    logic  quote_reg, quote_next;
    lead_t lead_reg, lead_next;
    logic  word_open_reg, word_open_next;

    always_comb
    begin
        lex_list_t l;
        logic      q;
        logic      wo;
        lead_t     ld;
        logic      used;

        l    = '0;
        q    = quote_reg;
        wo   = word_open_reg;
        ld   = LEAD_NONE;
        used = 1'b0;

        // Resolve the held lead against this byte.
        case (lead_reg)
            LEAD_GT:
            begin
                if (char_in == CH_GT)
                begin
                    l    = put_res(l, KIND_OP, 8'h00, OP_APPEND);
                    used = 1'b1;
                end
                else
                begin
                    l = put_res(l, KIND_OP, 8'h00, OP_REDIR_OU);
                end
            end
            LEAD_TWO:
            begin
                if (char_in == CH_GT)
                begin
                    if (wo)
                    begin
                        l = put_res(l, KIND_WEND, 8'h00, OP_APPEND);
                    end
                    wo   = 1'b0;
                    l    = put_res(l, KIND_OP, 8'h00, OP_REDIR_ER);
                    used = 1'b1;
                end
                else
                begin
                    l  = put_res(l, KIND_CHAR, CH_TWO, OP_APPEND);
                    wo = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Lex the byte itself.
        if (!used)
        begin
            if (q)
            begin
                if (char_in == CH_QUOTE)
                begin
                    q = 1'b0;
                end
                else
                begin
                    l  = put_res(l, KIND_CHAR, char_in, OP_APPEND);
                    wo = 1'b1;
                end
            end
            else if (char_in inside {8'h20, [8'h09:8'h0D]})
            begin
                if (wo)
                begin
                    l = put_res(l, KIND_WEND, 8'h00, OP_APPEND);
                end
                wo = 1'b0;
            end
            else if (char_in == CH_GT)
            begin
                if (wo)
                begin
                    l = put_res(l, KIND_WEND, 8'h00, OP_APPEND);
                end
                wo = 1'b0;
                ld = LEAD_GT;
            end
            else if (char_in == CH_TWO)
            begin
                ld = LEAD_TWO;
            end
            else if (char_in == CH_LT || char_in == CH_PIPE)
            begin
                if (wo)
                begin
                    l = put_res(l, KIND_WEND, 8'h00, OP_APPEND);
                end
                wo = 1'b0;
                l  = put_res(l, KIND_OP, 8'h00,
                             (char_in == CH_LT) ? OP_REDIR_IN : OP_PIPE);
            end
            else if (char_in == CH_QUOTE)
            begin
                q = 1'b1;
            end
            else
            begin
                l  = put_res(l, KIND_CHAR, char_in, OP_APPEND);
                wo = 1'b1;
            end
        end

        // Flush at line end: resolve the lead, close the word, mark the end.
        if (line_end)
        begin
            if (ld == LEAD_GT)
            begin
                l = put_res(l, KIND_OP, 8'h00, OP_REDIR_OU);
            end
            else if (ld == LEAD_TWO)
            begin
                l  = put_res(l, KIND_CHAR, CH_TWO, OP_APPEND);
                wo = 1'b1;
            end
            ld = LEAD_NONE;
            if (wo)
            begin
                l = put_res(l, KIND_WEND, 8'h00, OP_APPEND);
            end
            l  = put_res(l, KIND_EOL, 8'h00, OP_APPEND);
            q  = 1'b0;
            wo = 1'b0;
        end

        results        = l;
        quote_next     = q;
        lead_next      = ld;
        word_open_next = wo;
    end

    // Commit the state only when the byte's results move to the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg     <= 1'b0;
            lead_reg      <= LEAD_NONE;
            word_open_reg <= 1'b0;
        end
        else if (advance)
        begin
            quote_reg     <= quote_next;
            lead_reg      <= lead_next;
            word_open_reg <= word_open_next;
        end
    end

endmodule

>>> hw/rtl/slt_out_queue.sv
// ----------------------------------------------------------------------------
// slt_out_queue
// Result register: holds one byte's result list and hands it out in order.
// ----------------------------------------------------------------------------
module slt_out_queue
    import slt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  lex_list_t  list_in,
    output logic       can_load,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] char_out,
    output logic [2:0] operator_code,
    output logic       last
);

    result_t [MAX_RESULTS-1:0] slots_reg;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [IDX_W-1:0]          pos_reg, pos_next;
    result_t                   cur;
    logic                      take;

    assign cur           = slots_reg[pos_reg];
    assign out_valid     = (cnt_reg != '0);
    assign last          = (CNT_W'(pos_reg) + CNT_W'(1) == cnt_reg);
    assign kind          = cur.kind;
    assign char_out      = cur.ch;
    assign operator_code = cur.op;
    assign take          = out_valid && !out_stall;
    assign can_load      = !out_valid || (take && last);

    always_comb
    begin
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        if (load)
        begin
            cnt_next = list_in.count;
            pos_next = '0;
        end
        else if (take)
        begin
            if (last)
            begin
                cnt_next = '0;
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slots_reg <= list_in.res;
        end
    end

endmodule

>>> hw/rtl/shell_line_tokenizer.sv
// ----------------------------------------------------------------------------
// shell_line_tokenizer
// Streaming lexer for a shell command line: bytes in, token events out.
// ----------------------------------------------------------------------------
// Each accepted byte lands in an input register; one pass of decode logic
// turns it, with the lexer state, into zero to four results, which load into
// a four-slot result register that hands them out one per cycle while
// out_stall is low. So plain text and whitespace stream at one byte per
// cycle when the output does not stall; a byte with several results holds
// the result register until its last result is taken, and the input stalls
// meanwhile. The first result of a byte passes the input register and then
// the result register before it is valid, and is taken while out_stall is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shell_line_tokenizer
    import slt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] char_out,
    output logic [2:0] operator_code,
    output logic       last
);

    logic       hold_valid_reg;
    logic [7:0] char_reg;
    logic       line_end_reg;
    logic       can_load;
    logic       advance;
    logic       in_take;
    lex_list_t  lex_results;

    // Advance when the held byte exists and the result register frees up.
    assign advance  = hold_valid_reg && can_load;
    assign in_stall = hold_valid_reg && !can_load;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    // Capture the byte of each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg     <= char_in;
            line_end_reg <= line_end;
        end
    end

    slt_lexer u_lexer (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .char_in  (char_reg),
        .line_end (line_end_reg),
        .results  (lex_results)
    );

    slt_out_queue u_out_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .list_in       (lex_results),
        .can_load      (can_load),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .char_out      (char_out),
        .operator_code (operator_code),
        .last          (last)
    );

    // The input stalls only while a byte waits for the result register.
    `ASSERT_IMPLY(a_stall_needs_hold, clk, rst_n, in_stall, hold_valid_reg)
    // A taken result that is not the last leaves more results behind it.
    `ASSERT_NEXT(a_more_after_not_last, clk, rst_n,
                 out_valid && !out_stall && !last, out_valid)
    // End of line always closes a byte's result list.
    `ASSERT_IMPLY(a_eol_is_last, clk, rst_n, out_valid && kind == KIND_EOL, last)
    // Only word characters carry a byte.
    `ASSERT_IMPLY(a_char_zero, clk, rst_n,
                  out_valid && kind != KIND_CHAR, char_out == 8'h00)

endmodule

>>> verif/shell_line_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_line_tokenizer_tb
// Self-checking bench for the shell line tokenizer. A directed byte table
// comes first. Random command lines follow, built mostly from shell syntax
// with some noise mixed in. Untyped rows and all random bytes are scored by
// a predictor of the lexer. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module shell_line_tokenizer_tb
    import slt_pkg::*;
;

    localparam int RANDOM_ITEMS = 292;
    localparam int PAUSE_EVERY  = 100;   // drain the result path this often
    localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 48;    // settle time for stray results after the drain
    localparam int DIR_ROWS     = 28;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // The operator field reads zero outside operator tokens; zero is the append code.
    localparam op_t NO_OP = OP_APPEND;

    localparam result_t R_NONE   = '{kind: KIND_CHAR, ch: 8'h00, op: NO_OP};
    localparam result_t R_CHR_A  = '{kind: KIND_CHAR, ch: 8'h61, op: NO_OP};
    localparam result_t R_CHR_00 = '{kind: KIND_CHAR, ch: 8'h00, op: NO_OP};
    localparam result_t R_CHR_FF = '{kind: KIND_CHAR, ch: 8'hFF, op: NO_OP};
    localparam result_t R_WEND   = '{kind: KIND_WEND, ch: 8'h00, op: NO_OP};
    localparam result_t R_EOL    = '{kind: KIND_EOL,  ch: 8'h00, op: NO_OP};
    localparam result_t R_APPEND = '{kind: KIND_OP,   ch: 8'h00, op: OP_APPEND};
    localparam result_t R_ERR    = '{kind: KIND_OP,   ch: 8'h00, op: OP_REDIR_ER};
    localparam result_t R_OUT    = '{kind: KIND_OP,   ch: 8'h00, op: OP_REDIR_OU};
    localparam result_t R_IN     = '{kind: KIND_OP,   ch: 8'h00, op: OP_REDIR_IN};
    localparam result_t R_PIPE   = '{kind: KIND_OP,   ch: 8'h00, op: OP_PIPE};

    typedef result_t [0:MAX_RESULTS-1] result_row_t;
    localparam result_row_t NO_EXP = '{R_NONE, R_NONE, R_NONE, R_NONE};

    typedef struct packed {
        logic [7:0]  ch;
        logic        le;
        logic        typed;   // expected tokens given in the row itself
        logic [2:0]  n;
        result_row_t exp;
    } byte_row_t;

    typedef struct packed {
        result_t res;
        logic    last;
    } token_t;

    // ------------------------------------------------------------------------
    // Directed bytes. Rows without typed tokens are scored by the predictor.
    // Columns: byte, line end, typed, token count, tokens.
    // ------------------------------------------------------------------------
    byte_row_t byte_table [DIR_ROWS] = '{
        // field extremes as plain word characters
        '{8'h61,    1'b0, 1'b1, 3'd1, '{R_CHR_A,  R_NONE, R_NONE, R_NONE}},
        '{8'h00,    1'b0, 1'b1, 3'd1, '{R_CHR_00, R_NONE, R_NONE, R_NONE}},
        '{8'hFF,    1'b0, 1'b1, 3'd1, '{R_CHR_FF, R_NONE, R_NONE, R_NONE}},
        // '>' closes the word at once, then '>>' becomes append
        '{CH_GT,    1'b0, 1'b1, 3'd1, '{R_WEND,   R_NONE, R_NONE, R_NONE}},
        '{CH_GT,    1'b0, 1'b1, 3'd1, '{R_APPEND, R_NONE, R_NONE, R_NONE}},
        '{CH_LT,    1'b0, 1'b1, 3'd1, '{R_IN,     R_NONE, R_NONE, R_NONE}},
        '{CH_PIPE,  1'b0, 1'b1, 3'd1, '{R_PIPE,   R_NONE, R_NONE, R_NONE}},
        // '2' inside a word is held, then '2>' ends the word
        '{8'h66,    1'b0, 1'b0, 3'd0, NO_EXP},
        '{CH_TWO,   1'b0, 1'b1, 3'd0, NO_EXP},
        '{CH_GT,    1'b0, 1'b1, 3'd2, '{R_WEND,   R_ERR,  R_NONE, R_NONE}},
        // lone '>' then a word character: redirect out
        '{CH_GT,    1'b0, 1'b0, 3'd0, NO_EXP},
        '{8'h71,    1'b0, 1'b0, 3'd0, NO_EXP},
        // held '2' that turns out to be a word character
        '{CH_TWO,   1'b0, 1'b0, 3'd0, NO_EXP},
        '{8'h39,    1'b0, 1'b0, 3'd0, NO_EXP},
        // quoted whitespace and operator, then empty quotes inside the word
        '{CH_QUOTE, 1'b0, 1'b0, 3'd0, NO_EXP},
        '{CH_CR,    1'b0, 1'b0, 3'd0, NO_EXP},
        '{CH_PIPE,  1'b0, 1'b0, 3'd0, NO_EXP},
        '{CH_QUOTE, 1'b0, 1'b0, 3'd0, NO_EXP},
        '{CH_QUOTE, 1'b0, 1'b0, 3'd0, NO_EXP},
        '{CH_QUOTE, 1'b0, 1'b0, 3'd0, NO_EXP},
        '{CH_SPACE, 1'b0, 1'b0, 3'd0, NO_EXP},
        // held '>' resolved by the line end
        '{CH_GT,    1'b1, 1'b1, 3'd2, '{R_OUT,    R_EOL,  R_NONE, R_NONE}},
        // held '2' resolved by a word byte that ends the line: four tokens from one byte
        '{CH_TWO,   1'b0, 1'b0, 3'd0, NO_EXP},
        '{8'h78,    1'b1, 1'b0, 3'd0, NO_EXP},
        // unterminated quote flushed at line end, then a held '2' flushed at line end
        '{CH_QUOTE, 1'b0, 1'b0, 3'd0, NO_EXP},
        '{8'h7A,    1'b1, 1'b0, 3'd0, NO_EXP},
        '{CH_TWO,   1'b1, 1'b0, 3'd0, NO_EXP},
        // a blank line end yields only the end-of-line marker
        '{CH_SPACE, 1'b1, 1'b1, 3'd1, '{R_EOL,    R_NONE, R_NONE, R_NONE}}
    };

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [7:0] char_in       = 8'h00;
    logic       line_end      = 1'b0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [2:0] operator_code;
    logic       last;

    shell_line_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_in       (char_in),
        .line_end      (line_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .char_out      (char_out),
        .operator_code (operator_code),
        .last          (last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Lexer predictor: its own copy of the quote, lookahead and word state.
    // ------------------------------------------------------------------------
    logic    quote_open = 1'b0;
    lead_t   held_lead  = LEAD_NONE;
    logic    word_live  = 1'b0;
    result_t byte_tokens [$];
    token_t  expected_tokens [$];

    int mismatches  = 0;
    int idle_cycles = 0;
    int quiet_items = 0;

    function automatic void emit(kind_t k, logic [7:0] c, op_t o);
        byte_tokens.push_back('{kind: k, ch: c, op: o});
    endfunction

    function automatic void end_word();
        if (word_live)
            emit(KIND_WEND, 8'h00, NO_OP);
        word_live = 1'b0;
    endfunction

    function automatic void word_byte(logic [7:0] c);
        emit(KIND_CHAR, c, NO_OP);
        word_live = 1'b1;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Plain lexing of one byte once any held lead has been resolved.
    function automatic void lex_plain(logic [7:0] c);
        if (quote_open)
        begin
            if (c == CH_QUOTE)
                quote_open = 1'b0;
            else
                word_byte(c);
        end
        else if (is_blank(c))
            end_word();
        else if (c == CH_GT)
        begin
            end_word();
            held_lead = LEAD_GT;
        end
        else if (c == CH_TWO)
            held_lead = LEAD_TWO;
        else if (c == CH_LT)
        begin
            end_word();
            emit(KIND_OP, 8'h00, OP_REDIR_IN);
        end
        else if (c == CH_PIPE)
        begin
            end_word();
            emit(KIND_OP, 8'h00, OP_PIPE);
        end
        else if (c == CH_QUOTE)
            quote_open = 1'b1;
        else
            word_byte(c);
    endfunction

    // Advance the lexer by one byte; leave its tokens in byte_tokens.
    function automatic void tokenize(logic [7:0] c, logic le);
        bit consumed;
        lead_t lead;
        consumed = 1'b0;
        lead = held_lead;
        byte_tokens.delete();
        held_lead = LEAD_NONE;
        if (lead == LEAD_GT)
        begin
            if (c == CH_GT)
            begin
                emit(KIND_OP, 8'h00, OP_APPEND);
                consumed = 1'b1;
            end
            else
                emit(KIND_OP, 8'h00, OP_REDIR_OU);
        end
        else if (lead == LEAD_TWO)
        begin
            if (c == CH_GT)
            begin
                end_word();
                emit(KIND_OP, 8'h00, OP_REDIR_ER);
                consumed = 1'b1;
            end
            else
                word_byte(CH_TWO);
        end
        if (!consumed)
            lex_plain(c);
        if (le)
        begin
            // Resolve a held lead as if nothing followed, then flush the line.
            if (held_lead == LEAD_GT)
                emit(KIND_OP, 8'h00, OP_REDIR_OU);
            else if (held_lead == LEAD_TWO)
                word_byte(CH_TWO);
            held_lead = LEAD_NONE;
            end_word();
            emit(KIND_EOL, 8'h00, NO_OP);
            quote_open = 1'b0;
            word_live  = 1'b0;
        end
    endfunction

    function automatic void queue_tokens(result_row_t toks, int n);
        for (int j = 0; j < n; j++)
            expected_tokens.push_back('{res: toks[j], last: (j == n - 1)});
    endfunction

    function automatic void queue_predicted();
        for (int j = 0; j < byte_tokens.size(); j++)
            expected_tokens.push_back('{res: byte_tokens[j],
                                        last: (j == byte_tokens.size() - 1)});
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Mostly back-to-back, sometimes short gaps, rarely long ones.
    function automatic int pick_gap();
        int r;
        if (quiet_items > 0)
        begin
            quiet_items--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            quiet_items = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // One byte of a command line: shell syntax mostly, raw noise if asked.
    function automatic logic [7:0] shell_byte(bit noisy);
        int r;
        int ws;
        if (noisy)
            return 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 20)
            return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 30)
            return 8'($urandom_range(8'h30, 8'h39));
        if (r < 40)
            return CH_TWO;
        if (r < 53)
        begin
            ws = $urandom_range(0, 5);
            return (ws == 5) ? CH_SPACE : CH_TAB + 8'(ws);
        end
        if (r < 66)
            return CH_GT;
        if (r < 71)
            return CH_LT;
        if (r < 76)
            return CH_PIPE;
        if (r < 85)
            return CH_QUOTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Drive one transaction at the falling edge and return at the rising
    // edge that takes it. Valid stays up across back-to-back bytes.
    task automatic send_byte(input logic [7:0] c, input logic le);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        line_end <= le;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
    endtask

    // Hold the sender until every expected token has come out.
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall at random, with long open stretches now and then.
    // ------------------------------------------------------------------------
    initial
    begin
        int r;
        @(negedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                if (r < 92)
                    repeat ($urandom_range(1, 3)) @(negedge clk);
                else
                    repeat ($urandom_range(10, 30)) @(negedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: compare each result transaction with the oldest token.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tokens.size() == 0)
                report_mismatch($sformatf("unexpected token kind %0d char %02h op %0d",
                                          kind, char_out, operator_code));
            else
            begin
                want = expected_tokens.pop_front();
                if (kind !== want.res.kind)
                    report_mismatch($sformatf("kind got %0d want %0d", kind, want.res.kind));
                if (char_out !== want.res.ch)
                    report_mismatch($sformatf("char_out got %02h want %02h",
                                              char_out, want.res.ch));
                if (operator_code !== want.res.op)
                    report_mismatch($sformatf("operator_code got %0d want %0d",
                                              operator_code, want.res.op));
                if (last !== want.last)
                    report_mismatch($sformatf("last got %0b want %0b", last, want.last));
            end
        end
    end

    // Watchdog: end the run when neither side has moved for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, then random command lines.
    // ------------------------------------------------------------------------
    initial
    begin
        int i;
        int sent;
        int next_pause;
        int len;
        bit noisy;
        logic [7:0] c;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            send_byte(byte_table[i].ch, byte_table[i].le);
            tokenize(byte_table[i].ch, byte_table[i].le);
            if (byte_table[i].typed)
                queue_tokens(byte_table[i].exp, byte_table[i].n);
            else
                queue_predicted();
        end

        // Drain once between the table and the random lines.
        hold_until_drained();

        sent = 0;
        next_pause = PAUSE_EVERY;
        while (sent < RANDOM_ITEMS)
        begin
            // About one line in seven is raw noise; the rest follow shell syntax.
            noisy = ($urandom_range(0, 6) == 0);
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++)
            begin
                c = shell_byte(noisy);
                send_byte(c, i == len - 1);
                tokenize(c, i == len - 1);
                queue_predicted();
                sent++;
            end
            if (sent >= next_pause)
            begin
                hold_until_drained();
                next_pause += PAUSE_EVERY;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(negedge clk);
        // Let any stray tokens surface before the verdict.
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
